// ===== rtl/core/pmce_pkg.sv =====
// Shared types, codes and permutation functions for the permutation cipher mode engine.
// No dependencies; every other file of the block refers to this package by scoped names.
package pmce_pkg;

    localparam int BLOCK_BITS = 6;
    localparam int POS_W      = 3;
    localparam int SEG_W      = 3;
    localparam int KEY_W      = BLOCK_BITS * POS_W;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = KEY_W;

    localparam logic [MODE_W-1:0] MODE_ECB = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CBC = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CFB = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OFB = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CTR = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CIPHER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERM_KEY    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VECTOR = 2'd3;

    localparam logic [SEG_W-1:0] FULL_SEG = SEG_W'(BLOCK_BITS);

    typedef logic [BLOCK_BITS-1:0] blk_t;

    typedef struct packed {
        logic [MODE_W-1:0] cipher_mode;
        logic              direction;
        logic [KEY_W-1:0]  perm_key;
        blk_t              init_vector;
    } cfg_t;

    typedef struct packed {
        blk_t             data_in;
        logic [SEG_W-1:0] seg_bits;
        logic             starts_message;
    } item_t;

    typedef struct packed {
        blk_t             data_out;
        logic [SEG_W-1:0] out_bits;
        blk_t             chain_next;
    } dp_res_t;

    // Position 0 is the leftmost bit. Output position k takes input position key[k];
    // a source position beyond the block supplies a zero.
    function automatic blk_t enc_block(input blk_t x, input logic [KEY_W-1:0] key);
        blk_t             y;
        logic [POS_W-1:0] src;
        y = '0;
        for (int k = 0; k < BLOCK_BITS; k++) begin
            src = key[POS_W*k +: POS_W];
            if (src < POS_W'(BLOCK_BITS)) begin
                y[BLOCK_BITS-1-k] = x[POS_W'(BLOCK_BITS-1) - src];
            end
        end
        return y;
    endfunction

    // Inverse: input position k goes to output position key[k]; later k wins.
    function automatic blk_t dec_block(input blk_t y, input logic [KEY_W-1:0] key);
        blk_t             x;
        logic [POS_W-1:0] dst;
        x = '0;
        for (int k = 0; k < BLOCK_BITS; k++) begin
            dst = key[POS_W*k +: POS_W];
            if (dst < POS_W'(BLOCK_BITS)) begin
                x[POS_W'(BLOCK_BITS-1) - dst] = y[BLOCK_BITS-1-k];
            end
        end
        return x;
    endfunction

endpackage

// ===== rtl/core/pmce_item_if.sv =====
// Input channel of the permutation cipher mode engine: valid/ready plus one segment word.
// Depends on pmce_pkg for field widths.
interface pmce_item_if;
    logic                             valid;
    logic                             ready;
    logic [pmce_pkg::BLOCK_BITS-1:0]  data_in;
    logic [pmce_pkg::SEG_W-1:0]       seg_bits;
    logic                             starts_message;

    modport source (output valid, output data_in, output seg_bits, output starts_message,
                    input ready);
    modport sink   (input valid, input data_in, input seg_bits, input starts_message,
                    output ready);
endinterface

// ===== rtl/core/pmce_result_if.sv =====
// Result channel of the permutation cipher mode engine: valid/ready plus one segment word.
// Depends on pmce_pkg for field widths.
interface pmce_result_if;
    logic                             valid;
    logic                             ready;
    logic [pmce_pkg::BLOCK_BITS-1:0]  data_out;
    logic [pmce_pkg::SEG_W-1:0]       out_bits;

    modport source (output valid, output data_out, output out_bits, input ready);
    modport sink   (input valid, input data_out, input out_bits, output ready);
endinterface

// ===== rtl/core/pmce_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Depends on pmce_pkg for field widths.
interface pmce_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pmce_pkg::CFG_IDX_W-1:0]    index;
    logic [pmce_pkg::CFG_DATA_W-1:0]   wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/pmce_cfg_regs.sv =====
// Configuration register file of the permutation cipher mode engine.
// Depends on pmce_pkg and pmce_cfg_if.
module pmce_cfg_regs
(
    input  logic             clk,
    input  logic             rst_n,
    pmce_cfg_if.sink         cfg,
    output pmce_pkg::cfg_t   cfg_q
);

    pmce_pkg::cfg_t cfg_reg;
    pmce_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                pmce_pkg::REG_CIPHER_MODE:
                    cfg_next.cipher_mode = cfg.wdata[pmce_pkg::MODE_W-1:0];
                pmce_pkg::REG_DIRECTION:
                    cfg_next.direction = cfg.wdata[0];
                pmce_pkg::REG_PERM_KEY:
                    cfg_next.perm_key = cfg.wdata[pmce_pkg::KEY_W-1:0];
                pmce_pkg::REG_INIT_VECTOR:
                    cfg_next.init_vector = cfg.wdata[pmce_pkg::BLOCK_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/pmce_datapath.sv =====
// Single-pass cipher datapath: chain reload, segment masking, block permutation and
// chain update for all five modes. Depends on pmce_pkg.
module pmce_datapath
(
    input  pmce_pkg::cfg_t    cfg_q,
    input  pmce_pkg::item_t   item_q,
    input  pmce_pkg::blk_t    chain_q,
    output pmce_pkg::dp_res_t dp_res
);

    localparam logic [pmce_pkg::SEG_W-1:0] BLK_SEG = pmce_pkg::FULL_SEG;

    pmce_pkg::blk_t              chain_cur;
    pmce_pkg::blk_t              seg_mask;
    pmce_pkg::blk_t              d;
    pmce_pkg::blk_t              ks_full;
    pmce_pkg::blk_t              ks;
    pmce_pkg::blk_t              stream_res;
    pmce_pkg::blk_t              fb_word;
    logic [pmce_pkg::SEG_W-1:0]  s_eff;
    logic [pmce_pkg::SEG_W-1:0]  ks_shift;
    logic                        stream_mode;

    // Reload on message start; OFB starts from the encrypted IV.
    always_comb
    begin
        if (item_q.starts_message)
        begin
            if (cfg_q.cipher_mode == pmce_pkg::MODE_OFB)
            begin
                chain_cur = pmce_pkg::enc_block(cfg_q.init_vector, cfg_q.perm_key);
            end
            else
            begin
                chain_cur = cfg_q.init_vector;
            end
        end
        else
        begin
            chain_cur = chain_q;
        end
    end

    assign stream_mode = cfg_q.cipher_mode inside
                         {pmce_pkg::MODE_CFB, pmce_pkg::MODE_OFB, pmce_pkg::MODE_CTR};

    always_comb
    begin
        if (!stream_mode || item_q.seg_bits == '0 || item_q.seg_bits > BLK_SEG)
        begin
            s_eff = BLK_SEG;
        end
        else
        begin
            s_eff = item_q.seg_bits;
        end
    end

    assign seg_mask = ~({pmce_pkg::BLOCK_BITS{1'b1}} << s_eff);
    assign d        = item_q.data_in & seg_mask;
    assign ks_shift = BLK_SEG - s_eff;

    // OFB uses the chain word itself as keystream; CFB and CTR encrypt it.
    assign ks_full    = (cfg_q.cipher_mode == pmce_pkg::MODE_OFB) ? chain_cur
                        : pmce_pkg::enc_block(chain_cur, cfg_q.perm_key);
    assign ks         = ks_full >> ks_shift;
    assign stream_res = (ks ^ d) & seg_mask;
    assign fb_word    = cfg_q.direction ? d : stream_res;

    always_comb
    begin
        dp_res.out_bits   = s_eff;
        dp_res.data_out   = d;
        dp_res.chain_next = chain_cur;
        case (cfg_q.cipher_mode)
            pmce_pkg::MODE_ECB:
            begin
                dp_res.data_out = cfg_q.direction
                                  ? pmce_pkg::dec_block(d, cfg_q.perm_key)
                                  : pmce_pkg::enc_block(d, cfg_q.perm_key);
            end
            pmce_pkg::MODE_CBC:
            begin
                if (cfg_q.direction)
                begin
                    dp_res.data_out   = pmce_pkg::dec_block(d, cfg_q.perm_key) ^ chain_cur;
                    dp_res.chain_next = d;
                end
                else
                begin
                    dp_res.data_out   = pmce_pkg::enc_block(chain_cur ^ d, cfg_q.perm_key);
                    dp_res.chain_next = dp_res.data_out;
                end
            end
            pmce_pkg::MODE_CFB:
            begin
                dp_res.data_out   = stream_res;
                dp_res.chain_next = (chain_cur << s_eff) | fb_word;
            end
            pmce_pkg::MODE_OFB:
            begin
                dp_res.data_out   = stream_res;
                dp_res.chain_next = pmce_pkg::enc_block(chain_cur, cfg_q.perm_key);
            end
            pmce_pkg::MODE_CTR:
            begin
                dp_res.data_out   = stream_res;
                dp_res.chain_next = chain_cur + pmce_pkg::BLOCK_BITS'(1);
            end
            default:
            begin
                // Unused mode codes pass the word through.
                dp_res.data_out = d;
            end
        endcase
    end

endmodule

// ===== rtl/core/permutation_cipher_mode_engine_core.sv =====
// Top level of the permutation cipher mode engine.
// Depends on pmce_pkg, the channel interfaces, pmce_cfg_regs and pmce_datapath.

// Encrypts or decrypts one segment word of up to six bits per item with a six-bit
// bit-permutation block cipher run in ECB, CBC, CFB, OFB or CTR mode. Each accepted
// word produces exactly one result word, in order. An item enters an input register,
// passes through permutation, XOR and chain update, then lands in the result register.
// The block takes a new word every cycle while the result slot is free or drained; the
// sustained rate is one word per cycle, set by the single chain register that each word
// reads and updates in the cycle it leaves the input register. While the result is not
// taken, the input register still accepts one word, then both stages hold. Set
// starts_message on the first word of a message to reload the chain from init_vector
// (from its encryption in OFB). Write configuration only while idle.
module permutation_cipher_mode_engine_core
(
    input  logic        clk,
    input  logic        rst_n,
    pmce_cfg_if.sink    cfg,
    pmce_item_if.sink   item,
    pmce_result_if.source result
);

    pmce_pkg::cfg_t    cfg_q;
    pmce_pkg::dp_res_t dp_res;

    // Input stage.
    logic              stg_vld_reg;
    logic              stg_vld_next;
    pmce_pkg::item_t   stg_data_reg;

    // Result stage.
    logic                        res_vld_reg;
    logic                        res_vld_next;
    pmce_pkg::blk_t              res_data_reg;
    logic [pmce_pkg::SEG_W-1:0]  res_bits_reg;

    // Chain, shift register or counter, depending on mode.
    pmce_pkg::blk_t    chain_reg;
    pmce_pkg::blk_t    chain_next;

    logic advance;
    logic take;
    logic fire;

    pmce_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    pmce_datapath u_datapath
    (
        .cfg_q  (cfg_q),
        .item_q (stg_data_reg),
        .chain_q(chain_reg),
        .dp_res (dp_res)
    );

    // Advance the pipe whenever the result slot is free or being drained.
    assign advance    = !res_vld_reg || result.ready;
    assign item.ready = !stg_vld_reg || advance;
    assign take       = item.valid && item.ready;
    // A word leaves the input stage and commits its chain update.
    assign fire       = stg_vld_reg && advance;

    assign stg_vld_next = take ? 1'b1 : (advance ? 1'b0 : stg_vld_reg);
    assign res_vld_next = advance ? stg_vld_reg : res_vld_reg;
    assign chain_next   = fire ? dp_res.chain_next : chain_reg;

    assign result.valid    = res_vld_reg;
    assign result.data_out = res_data_reg;
    assign result.out_bits = res_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
            chain_reg   <= '0;
        end
        else
        begin
            stg_vld_reg <= stg_vld_next;
            res_vld_reg <= res_vld_next;
            chain_reg   <= chain_next;
        end
    end

    // Payload registers: input on handshake, result when a word leaves the input stage.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stg_data_reg.data_in        <= item.data_in;
            stg_data_reg.seg_bits       <= item.seg_bits;
            stg_data_reg.starts_message <= item.starts_message;
        end
        if (fire)
        begin
            res_data_reg <= dp_res.data_out;
            res_bits_reg <= dp_res.out_bits;
        end
    end

`ifndef SYNTHESIS
    // An empty result slot never blocks the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_vld_reg |-> item.ready)
        else $error("input stalled with empty result stage");

    // A stalled input stage keeps its word.
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stg_vld_reg && !advance |=> stg_vld_reg && $stable(stg_data_reg))
        else $error("input stage lost its word during a stall");

    // Result length stays within the block.
    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg |-> res_bits_reg != '0 && res_bits_reg <= pmce_pkg::FULL_SEG)
        else $error("out_bits outside 1..block size");

    // No result bits above the segment length.
    a_bits_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg |-> (res_data_reg >> res_bits_reg) == '0)
        else $error("data_out has bits above out_bits");

    // The chain moves only when a word is processed.
    a_chain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(chain_reg))
        else $error("chain register changed without a word");
`endif

endmodule
